### hw/rtl/cqp_pkg.sv
// cqp_pkg: shared types and defaults for the circular queue with purge
// no dependencies; imported by the queue core
`default_nettype none

package cqp_pkg;

   // default geometry of the key store
   localparam int unsigned DEPTH_DEF     = 32;
   localparam int unsigned KEY_WIDTH_DEF = 32;

   // width of the key fields on the request and response ports
   localparam int unsigned KEY_IO_W = 32;

   // operation codes carried on req_mode
   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_PURGE   = 2'd2,
      OP_REVERSE = 2'd3
   } cqp_op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_PG_RD,
      ST_PG_WR,
      ST_RV_RDA,
      ST_RV_RDB,
      ST_RV_WRA,
      ST_RV_WRB,
      ST_FINISH
   } cqp_state_type;

endpackage

`default_nettype wire

### hw/rtl/cqp_ram.sv
// cqp_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cqp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/circular_queue_with_purge_core.sv
// circular_queue_with_purge_core: ring-buffer queue of signed keys with
// push, pop, purge of negative keys and in-place reversal
// depends on cqp_pkg and cqp_ram
//
// usage
// - request channel (req_valid/req_ready, req_mode, req_key_in) takes one
//   operation per transfer; response channel (rsp_valid/rsp_ready) returns
//   exactly one result per request: rsp_ok, rsp_key_out, rsp_occupancy
// - one operation is worked at a time by a small sequencer around a shared
//   position adder (head plus offset, wrapped at DEPTH) and one ram port
// - per operation: push writes at head plus count; pop reads the head key,
//   skipped when empty (the ram read is registered); purge reads then
//   conditionally writes each held key; reverse reads both keys of each
//   swapped pair and writes them back exchanged
// - req_ready is high only while the sequencer is idle, which it is again
//   from the cycle rsp_valid rises; the result sits in an output register,
//   so a new request may transfer while the previous response is still
//   stalled by rsp_ready low
// - if the receiver stalls, the next finished result waits in the
//   sequencer until the output register frees up
// - reset empties the queue (head and count cleared) and drops any pending
//   response; the key store itself is not cleared and needs no sweep
`default_nettype none

module circular_queue_with_purge_core
   import cqp_pkg::*;
#(
   parameter int unsigned DEPTH     = DEPTH_DEF,
   parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic signed [KEY_IO_W-1:0]    req_key_in,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ok,
   output logic signed [KEY_IO_W-1:0]         rsp_key_out,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   // control state
   cqp_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] tmp_ff, tmp_in;
   logic [CNT_W-1:0]     idx_a_ff, idx_a_in;   // purge read index, reverse low index
   logic [CNT_W-1:0]     idx_b_ff, idx_b_in;   // purge kept count, reverse high index
   logic                 ok_ff, ok_in;
   logic [KEY_IO_W-1:0]  kout_ff, kout_in;

   // response registers
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [KEY_IO_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [CNT_W-1:0]     rsp_occ_ff, rsp_occ_in;

   // shared position adder
   logic [CNT_W-1:0] pos_off;
   logic [SUM_W-1:0] pos_sum;
   logic [IDX_W-1:0] pos_addr;

   // ram port
   logic                 ram_wr_en;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   logic       req_xfer;
   cqp_op_type req_op;
   logic [CNT_W-1:0] idx_a_next;
   logic [CNT_W-1:0] kept_next;

   assign req_op    = cqp_op_type'(req_mode);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // head plus offset, wrapped once at DEPTH
   always_comb begin
      pos_sum = SUM_W'(head_ff) + SUM_W'(pos_off);
      if (pos_sum >= SUM_W'(DEPTH)) begin
         pos_addr = IDX_W'(pos_sum - SUM_W'(DEPTH));
      end else begin
         pos_addr = IDX_W'(pos_sum);
      end
   end

   cqp_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_addr),
      .rd_data (ram_rd_data)
   );

   assign idx_a_next = idx_a_ff + CNT_W'(1);
   assign kept_next  = idx_b_ff + CNT_W'(!ram_rd_data[KEY_WIDTH-1]);

   // sequencer: next state, datapath updates and ram control
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      tmp_in       = tmp_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      ok_in        = ok_ff;
      kout_in      = kout_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_off      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_data  = key_ff;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               key_in   = KEY_WIDTH'(req_key_in);
               kout_in  = '0;
               ok_in    = 1'b0;
               idx_a_in = '0;
               idx_b_in = count_ff - CNT_W'(1);
               unique case (req_op)
                  OP_PUSH: state_in = ST_PUSH;
                  OP_POP:  state_in = ST_POP_RD;
                  OP_PURGE: begin
                     idx_b_in = '0;
                     if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_PG_RD;
                     end
                  end
                  OP_REVERSE: begin
                     ok_in = 1'b1;
                     if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_RV_RDA;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end

         ST_PUSH: begin
            pos_off = count_ff;
            if (count_ff < CNT_W'(DEPTH)) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               ok_in     = 1'b1;
            end
            state_in = ST_FINISH;
         end

         ST_POP_RD: begin
            if (count_ff != '0) begin
               ram_rd_en = 1'b1;
               state_in  = ST_POP_WAIT;
            end else begin
               state_in  = ST_FINISH;
            end
         end

         ST_POP_WAIT: begin
            pos_off  = CNT_W'(1);
            kout_in  = KEY_IO_W'(signed'(ram_rd_data));
            head_in  = pos_addr;
            count_in = count_ff - CNT_W'(1);
            ok_in    = 1'b1;
            state_in = ST_FINISH;
         end

         ST_PG_RD: begin
            pos_off   = idx_a_ff;
            ram_rd_en = 1'b1;
            state_in  = ST_PG_WR;
         end

         ST_PG_WR: begin
            // kept keys are packed down toward the head
            pos_off     = idx_b_ff;
            ram_wr_data = ram_rd_data;
            ram_wr_en   = !ram_rd_data[KEY_WIDTH-1];
            idx_b_in    = kept_next;
            idx_a_in    = idx_a_next;
            if (idx_a_next == count_ff) begin
               count_in = kept_next;
               ok_in    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PG_RD;
            end
         end

         ST_RV_RDA: begin
            pos_off = idx_a_ff;
            if (idx_a_ff < idx_b_ff) begin
               ram_rd_en = 1'b1;
               state_in  = ST_RV_RDB;
            end else begin
               state_in  = ST_FINISH;
            end
         end

         ST_RV_RDB: begin
            pos_off   = idx_b_ff;
            tmp_in    = ram_rd_data;
            ram_rd_en = 1'b1;
            state_in  = ST_RV_WRA;
         end

         ST_RV_WRA: begin
            pos_off     = idx_a_ff;
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            state_in    = ST_RV_WRB;
         end

         ST_RV_WRB: begin
            pos_off     = idx_b_ff;
            ram_wr_en   = 1'b1;
            ram_wr_data = tmp_ff;
            idx_a_in    = idx_a_next;
            idx_b_in    = idx_b_ff - CNT_W'(1);
            state_in    = ST_RV_RDA;
         end

         ST_FINISH: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_key_in   = kout_ff;
               rsp_occ_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      tmp_ff     <= tmp_in;
      idx_a_ff   <= idx_a_in;
      idx_b_ff   <= idx_b_in;
      ok_ff      <= ok_in;
      kout_ff    <= kout_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_key_ff <= rsp_key_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

`default_nettype wire
